// File: rtl/rv64_pkg.sv
package rv64_pkg;

   // Major opcodes.
   localparam logic [6:0] OP_REG   = 7'h33;
   localparam logic [6:0] OP_REGW  = 7'h3b;
   localparam logic [6:0] OP_LOAD  = 7'h03;
   localparam logic [6:0] OP_IMM   = 7'h13;
   localparam logic [6:0] OP_IMMW  = 7'h1b;
   localparam logic [6:0] OP_STORE = 7'h23;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_JAL   = 7'h6f;
   localparam logic [6:0] OP_JALR  = 7'h67;
   localparam logic [6:0] OP_LUI   = 7'h37;
   localparam logic [6:0] OP_AUIPC = 7'h17;
   localparam logic [6:0] OP_SYSTEM = 7'h73;

   // Configuration register indexes.
   localparam logic CSR_START = 1'b0;
   localparam logic CSR_STACK = 1'b1;

   localparam logic [31:0] START_RESET = 32'd984;
   localparam logic [31:0] STACK_RESET = 32'd10000;

   // Long operations run on the shared iterative unit.
   localparam logic [1:0] LOP_MUL  = 2'd0;
   localparam logic [1:0] LOP_MULH = 2'd1;
   localparam logic [1:0] LOP_DIV  = 2'd2;
   localparam logic [1:0] LOP_REM  = 2'd3;

   typedef struct packed {
      logic       start;
      logic [1:0] op;
      logic       word;
   } lunit_cmd_type;

   typedef struct packed {
      logic [63:0] next_pc;
      logic        reg_written;
      logic [4:0]  dest_index;
      logic [63:0] dest_value;
      logic        store_done;
      logic [63:0] store_address;
      logic [63:0] store_value;
      logic        branch_taken;
      logic        illegal;
   } rsp_word_type;

endpackage

// File: rtl/rv64_if.sv
interface rv64_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instruction;
   modport source (output valid, output instruction, input ready);
   modport sink (input valid, input instruction, output ready);
endinterface

interface rv64_rsp_if;
   import rv64_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// File: rtl/rv64_ram.sv
module rv64_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: rtl/rv64_lunit.sv
module rv64_lunit import rv64_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  lunit_cmd_type cmd,
   input  logic [63:0]   opa,
   input  logic [63:0]   opb,
   output logic          done,
   output logic [63:0]   result
);
   // Shift-add multiply and restoring divide, one bit a cycle on magnitudes (MUL on raw operands).
   logic [6:0]   count_ff, count_in;
   logic         busy_ff, busy_in;
   logic [1:0]   op_ff, op_in;
   logic         word_ff, word_in;
   logic         neg_ff, neg_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  dvs_ff, dvs_in;
   logic [63:0]  spec_ff, spec_in;
   logic         use_spec_ff, use_spec_in;
   logic         done_ff, done_in;
   logic [63:0]  res_ff, res_in;

   logic [63:0]  a_x, b_x, a_mag, b_mag, part, step_hi;
   logic         a_neg, b_neg, is_div, ovf;
   logic [64:0]  sum, diff;
   logic [127:0] fin;
   logic [63:0]  fin_sel;

   always_comb begin
      // Operands widened for W forms.
      a_x    = cmd.word ? {{32{opa[31]}}, opa[31:0]} : opa;
      b_x    = cmd.word ? {{32{opb[31]}}, opb[31:0]} : opb;
      is_div = cmd.op == LOP_DIV || cmd.op == LOP_REM;
      a_neg  = a_x[63] && cmd.op != LOP_MUL;
      b_neg  = b_x[63] && cmd.op != LOP_MUL;
      a_mag  = a_neg ? 64'd0 - a_x : a_x;
      b_mag  = b_neg ? 64'd0 - b_x : b_x;
      ovf    = cmd.word ? (a_x == 64'hffff_ffff_8000_0000)
                        : (a_x == 64'h8000_0000_0000_0000);

      busy_in     = busy_ff;
      count_in    = count_ff;
      op_in       = op_ff;
      word_in     = word_ff;
      neg_in      = neg_ff;
      acc_in      = acc_ff;
      dvs_in      = dvs_ff;
      spec_in     = spec_ff;
      use_spec_in = use_spec_ff;
      done_in     = 1'b0;
      res_in      = res_ff;

      part    = acc_ff[0] ? dvs_ff : 64'd0;
      sum     = {1'b0, acc_ff[127:64]} + {1'b0, part};
      step_hi = acc_ff[126:63];
      diff    = {1'b0, step_hi} - {1'b0, dvs_ff};

      if (cmd.start) begin
         busy_in     = 1'b1;
         count_in    = 7'd64;
         op_in       = cmd.op;
         word_in     = cmd.word;
         acc_in      = {64'd0, a_mag};
         dvs_in      = b_mag;
         use_spec_in = 1'b0;
         spec_in     = 64'd0;
         if (cmd.op == LOP_REM) begin
            neg_in = a_neg;
         end else begin
            neg_in = a_neg ^ b_neg;
         end
         if (is_div && b_x == 64'd0) begin
            use_spec_in = 1'b1;
            spec_in     = (cmd.op == LOP_DIV) ? 64'hffff_ffff_ffff_ffff : a_x;
         end else if (is_div && ovf && b_x == 64'hffff_ffff_ffff_ffff) begin
            use_spec_in = 1'b1;
            spec_in     = (cmd.op == LOP_DIV) ? a_x : 64'd0;
         end
      end else if (busy_ff) begin
         if (count_ff != 7'd0) begin
            count_in = count_ff - 7'd1;
            if (op_ff == LOP_MUL || op_ff == LOP_MULH) begin
               acc_in = {sum, acc_ff[63:1]};
            end else if (!diff[64]) begin
               acc_in = {diff[63:0], acc_ff[62:0], 1'b1};
            end else begin
               acc_in = {step_hi, acc_ff[62:0], 1'b0};
            end
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = fin_sel;
         end
      end

      // Final sign fix and selection.
      fin = neg_ff ? 128'd0 - acc_ff : acc_ff;
      case (op_ff)
         LOP_MUL:  fin_sel = acc_ff[63:0];
         LOP_MULH: fin_sel = fin[127:64];
         LOP_DIV:  fin_sel = neg_ff ? 64'd0 - acc_ff[63:0] : acc_ff[63:0];
         LOP_REM:  fin_sel = neg_ff ? 64'd0 - acc_ff[127:64] : acc_ff[127:64];
         default:  fin_sel = 64'd0;
      endcase
      if (use_spec_ff) begin
         fin_sel = spec_ff;
      end
      if (word_ff) begin
         fin_sel = {{32{fin_sel[31]}}, fin_sel[31:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff    <= count_in;
      op_ff       <= op_in;
      word_ff     <= word_in;
      neg_ff      <= neg_in;
      acc_ff      <= acc_in;
      dvs_ff      <= dvs_in;
      spec_ff     <= spec_in;
      use_spec_ff <= use_spec_in;
      res_ff      <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

`ifndef ASSERT_OFF
   // A finished result only follows a running operation.
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   // Busy and done never overlap.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(done_ff && busy_ff && !$past(cmd.start))) else $error("done while busy");
   // The step count only falls while busy.
   a_count: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !$past(cmd.start) && $past(busy_ff))
      |-> count_ff == $past(count_ff) - 7'd1) else $error("count slip");
`endif
endmodule

// File: rtl/rv64im_instruction_execute.sv
// RV64IM instruction execute block.
// req carries one 32-bit instruction word fetched at the internal PC; rsp
// returns one word per instruction: next PC, register writeback, store,
// branch and illegal flags. csr_ writes set the start address (index 0,
// also loads the PC) and the initial stack pointer (index 1, also loads x2).
// One instruction at a time: req_ready is high only when idle and the
// output register is free. A plain instruction is executed in ST_EXEC and
// its result registered in the output register; a load passes through
// ST_LOAD as well, for the registered store read. The next word can be
// taken in the cycle after the result leaves.
// MUL, MULH, DIV, REM and the W forms of MUL, DIV and REM run on one shared
// bit-serial unit, 64 steps plus setup and finish; ST_WAIT then takes the result.
// After reset a clearing pass writes zero into each data store entry, one
// entry a cycle, with req_ready low meanwhile.
// When the receiver stalls, the result waits in the output register and no
// new instruction is taken until it leaves.
module rv64im_instruction_execute import rv64_pkg::*; #(
   parameter int DATA_WORDS = 4096
) (
   input  logic          clock,
   input  logic          reset,
   rv64_req_if.sink      req,
   rv64_rsp_if.source    rsp,
   input  logic          csr_write,
   input  logic          csr_index,
   input  logic [31:0]   csr_data
);
   localparam int AW = $clog2(DATA_WORDS);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_LONG  = 3'd4;
   localparam logic [2:0] ST_WAIT  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [AW:0] clr_ff, clr_in;
   logic [63:0] pc_ff, pc_in;
   logic [63:0] regs_ff [32];
   logic [31:0] ins_ff, ins_in;
   logic [63:0] a_ff, a_in, b_ff, b_in;
   logic        out_valid_ff, out_valid_in;
   rsp_word_type out_ff, out_in;

   logic [6:0]  op;
   logic [4:0]  rd, rs1, rs2;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [5:0]  f6, shamt;
   logic [63:0] immi, imms, immb, immj, immu;
   logic [63:0] ea, val, npc, saddr, sval, load_e;
   logic        wr, st, taken, bad, cond, is_long, is_load;
   logic [1:0]  lop;
   lunit_cmd_type cmd;
   logic        lu_done;
   logic [63:0] lu_res;
   logic        ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [63:0] ram_wd, ram_rd;
   logic        accept;
   rsp_word_type res;

   assign accept    = req.valid && req.ready;
   assign req.ready = state_ff == ST_IDLE && !out_valid_ff;
   assign rsp.valid = out_valid_ff;
   assign rsp.word  = out_ff;

   // Decode of the latched instruction.
   always_comb begin
      op    = ins_ff[6:0];
      rd    = ins_ff[11:7];
      f3    = ins_ff[14:12];
      rs1   = ins_ff[19:15];
      rs2   = ins_ff[24:20];
      f7    = ins_ff[31:25];
      f6    = ins_ff[31:26];
      shamt = ins_ff[25:20];
      immi  = {{52{ins_ff[31]}}, ins_ff[31:20]};
      imms  = {{52{ins_ff[31]}}, ins_ff[31:25], ins_ff[11:7]};
      immb  = {{51{ins_ff[31]}}, ins_ff[31], ins_ff[7], ins_ff[30:25], ins_ff[11:8], 1'b0};
      immj  = {{43{ins_ff[31]}}, ins_ff[31], ins_ff[19:12], ins_ff[20], ins_ff[30:21], 1'b0};
      immu  = {{32{ins_ff[31]}}, ins_ff[31:12], 12'd0};
      ea    = a_ff + immi;
      saddr = a_ff + imms;
   end

   // Execute: one result word from the latched operands.
   always_comb begin
      val = 64'd0; npc = pc_ff + 64'd4; sval = 64'd0;
      wr = 1'b0; st = 1'b0; taken = 1'b0; bad = 1'b0; cond = 1'b0;
      is_long = 1'b0; is_load = 1'b0; lop = LOP_MUL;
      case (op)
         OP_REG: begin
            wr = 1'b1;
            if (f7 == 7'h00) begin
               case (f3)
                  3'd0: val = a_ff + b_ff;
                  3'd1: val = a_ff << b_ff[5:0];
                  3'd2: val = {63'd0, $signed(a_ff) < $signed(b_ff)};
                  3'd4: val = a_ff ^ b_ff;
                  3'd5: val = a_ff >> b_ff[5:0];
                  3'd6: val = a_ff | b_ff;
                  3'd7: val = a_ff & b_ff;
                  default: bad = 1'b1;
               endcase
            end else if (f7 == 7'h20 && f3 == 3'd0) begin
               val = a_ff - b_ff;
            end else if (f7 == 7'h20 && f3 == 3'd5) begin
               val = $unsigned($signed(a_ff) >>> b_ff[5:0]);
            end else if (f7 == 7'h01 && (f3 == 3'd0 || f3 == 3'd1
                                         || f3 == 3'd4 || f3 == 3'd6)) begin
               is_long = 1'b1;
               case (f3)
                  3'd0:    lop = LOP_MUL;
                  3'd1:    lop = LOP_MULH;
                  3'd4:    lop = LOP_DIV;
                  default: lop = LOP_REM;
               endcase
            end else begin
               bad = 1'b1;
            end
         end
         OP_REGW: begin
            wr = 1'b1;
            if (f7 == 7'h00 && f3 == 3'd0) begin
               val = a_ff + b_ff; val = {{32{val[31]}}, val[31:0]};
            end else if (f7 == 7'h20 && f3 == 3'd0) begin
               val = a_ff - b_ff; val = {{32{val[31]}}, val[31:0]};
            end else if (f7 == 7'h01 && (f3 == 3'd0 || f3 == 3'd4 || f3 == 3'd6)) begin
               is_long = 1'b1;
               lop = (f3 == 3'd0) ? LOP_MUL : (f3 == 3'd4) ? LOP_DIV : LOP_REM;
            end else begin
               bad = 1'b1;
            end
         end
         OP_LOAD: begin
            wr = 1'b1;
            if (f3 <= 3'd3) is_load = 1'b1; else bad = 1'b1;
         end
         OP_IMM: begin
            wr = 1'b1;
            case (f3)
               3'd0: val = a_ff + immi;
               3'd1: if (f6 == 6'd0) val = a_ff << shamt; else bad = 1'b1;
               3'd2: val = {63'd0, $signed(a_ff) < $signed(immi)};
               3'd4: val = a_ff ^ immi;
               3'd5: begin
                  if (f6 == 6'd0) val = a_ff >> shamt;
                  else if (f6 == 6'h10) val = $unsigned($signed(a_ff) >>> shamt);
                  else bad = 1'b1;
               end
               3'd6: val = a_ff | immi;
               3'd7: val = a_ff & immi;
               default: bad = 1'b1;
            endcase
         end
         OP_IMMW: begin
            wr = 1'b1;
            if (f3 == 3'd0) val = {{32{ea[31]}}, ea[31:0]}; else bad = 1'b1;
         end
         OP_STORE: begin
            if (f3 <= 3'd3) begin
               st = 1'b1;
               case (f3)
                  3'd0:    sval = {56'd0, b_ff[7:0]};
                  3'd1:    sval = {48'd0, b_ff[15:0]};
                  3'd2:    sval = {32'd0, b_ff[31:0]};
                  default: sval = b_ff;
               endcase
            end else begin
               bad = 1'b1;
            end
         end
         OP_BRANCH: begin
            case (f3)
               3'd0: cond = a_ff == b_ff;
               3'd1: cond = a_ff != b_ff;
               3'd4: cond = $signed(a_ff) < $signed(b_ff);
               3'd5: cond = !($signed(a_ff) < $signed(b_ff));
               default: bad = 1'b1;
            endcase
            if (cond) begin
               taken = 1'b1; npc = pc_ff + immb;
            end
         end
         OP_JAL: begin
            wr = 1'b1; val = pc_ff + 64'd4; taken = 1'b1; npc = pc_ff + immj;
         end
         OP_JALR: begin
            if (f3 == 3'd0) begin
               wr = 1'b1; val = pc_ff + 64'd4; taken = 1'b1; npc = {ea[63:1], 1'b0};
            end else begin
               bad = 1'b1;
            end
         end
         OP_LUI:   begin wr = 1'b1; val = immu; end
         OP_AUIPC: begin wr = 1'b1; val = pc_ff + immu; end
         OP_SYSTEM: if (!(f3 == 3'd0 && f7 == 7'd0)) bad = 1'b1;
         default: bad = 1'b1;
      endcase

      // Load data from the registered store read.
      case (f3[1:0])
         2'd0:    load_e = {{56{ram_rd[7]}}, ram_rd[7:0]};
         2'd1:    load_e = {{48{ram_rd[15]}}, ram_rd[15:0]};
         2'd2:    load_e = {{32{ram_rd[31]}}, ram_rd[31:0]};
         default: load_e = ram_rd;
      endcase
      if (state_ff == ST_LOAD) val = load_e;
      if (state_ff == ST_WAIT) val = lu_res;

      if (bad) begin
         wr = 1'b0; st = 1'b0; taken = 1'b0; npc = pc_ff + 64'd4; val = 64'd0;
      end
      if (rd == 5'd0) wr = 1'b0;

      res.next_pc       = npc;
      res.reg_written   = wr;
      res.dest_index    = wr ? rd : 5'd0;
      res.dest_value    = wr ? val : 64'd0;
      res.store_done    = st;
      res.store_address = st ? saddr : 64'd0;
      res.store_value   = sval;
      res.branch_taken  = taken;
      res.illegal       = bad;
   end

   assign cmd.start = state_ff == ST_EXEC && is_long && !bad;
   assign cmd.op    = lop;
   assign cmd.word  = op == OP_REGW;

   rv64_lunit u_lunit (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .opa    (a_ff),
      .opb    (b_ff),
      .done   (lu_done),
      .result (lu_res)
   );

   // Data store port: clearing pass, or the store of the executing word.
   always_comb begin
      ram_ra = ea[AW+1:2];
      if (state_ff == ST_CLEAR) begin
         ram_we = 1'b1; ram_wa = clr_ff[AW-1:0]; ram_wd = 64'd0;
      end else begin
         ram_we = state_ff == ST_EXEC && st;
         ram_wa = saddr[AW+1:2];
         ram_wd = sval;
      end
   end

   rv64_ram #(.WIDTH(64), .DEPTH(DATA_WORDS)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pc_in        = pc_ff;
      ins_in       = ins_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_in       = out_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + {{AW{1'b0}}, 1'b1};
            if (clr_ff == (AW+1)'(DATA_WORDS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               ins_in   = req.instruction;
               a_in     = regs_ff[req.instruction[19:15]];
               b_in     = regs_ff[req.instruction[24:20]];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (is_load && !bad) begin
               state_in = ST_LOAD;
            end else if (is_long && !bad) begin
               state_in = ST_LONG;
            end else begin
               state_in = ST_IDLE; out_valid_in = 1'b1; out_in = res;
               pc_in = res.next_pc;
            end
         end
         ST_LONG: if (lu_done) state_in = ST_WAIT;
         ST_LOAD, ST_WAIT: begin
            state_in = ST_IDLE; out_valid_in = 1'b1; out_in = res;
            pc_in = res.next_pc;
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_write && csr_index == CSR_START) pc_in = {32'd0, csr_data};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
         pc_ff        <= {32'd0, START_RESET};
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
         pc_ff        <= pc_in;
      end
      ins_ff <= ins_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      out_ff <= out_in;
   end

   // Register file with writeback at result time; x0 stays zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) begin
            regs_ff[i] <= (i == 2) ? {32'd0, STACK_RESET} : 64'd0;
         end
      end else if (csr_write && csr_index == CSR_STACK) begin
         regs_ff[2] <= {32'd0, csr_data};
      end else if (out_valid_in && !out_valid_ff && res.reg_written) begin
         regs_ff[rd] <= res.dest_value;
      end
   end

`ifndef ASSERT_OFF
   // A held result stays valid while the receiver stalls.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("result lost");
   // A result leaves the sequencer only from a working state.
   a_src: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) != ST_IDLE) else $error("stray result");
   // x0 is never reported as written.
   a_x0: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.reg_written && out_ff.dest_index == 5'd0))
      else $error("x0 written");
`endif
endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rv64_pkg::*;

   // Function codes used by the predictor and the instruction builders.
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;
   localparam logic [2:0] F3_MUL  = 3'd0;
   localparam logic [2:0] F3_MULH = 3'd1;
   localparam logic [2:0] F3_DIV  = 3'd4;
   localparam logic [2:0] F3_REM  = 3'd6;
   localparam logic [2:0] F3_B    = 3'd0;
   localparam logic [2:0] F3_H    = 3'd1;
   localparam logic [2:0] F3_W    = 3'd2;
   localparam logic [2:0] F3_D    = 3'd3;
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;
   localparam logic [6:0] F7_MD   = 7'h01;
   localparam logic [5:0] F6_SRA  = 6'h10;
   localparam int         RND_PER_PHASE = 360;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         SETTLE_CYCLES = 100;

   // Predicts each result word from its instruction and checks the block's output.
   class rv64_scoreboard;
      logic [63:0]  regs [32];
      logic [63:0]  pc;
      logic [63:0]  mem [4096];
      rsp_word_type expected_words [$];
      int           errors;

      function new();
         foreach (regs[i]) regs[i] = '0;
         foreach (mem[i]) mem[i] = '0;
         regs[2] = {32'd0, STACK_RESET};
         pc = {32'd0, START_RESET};
         errors = 0;
      endfunction

      function void write_csr(logic idx, logic [31:0] data);
         if (idx == CSR_START) pc = {32'd0, data};
         else regs[2] = {32'd0, data};
      endfunction

      function logic [63:0] sdiv(logic [63:0] a, logic [63:0] b, bit want_rem);
         if (b == '0) return want_rem ? a : '1;
         if (a == 64'h8000_0000_0000_0000 && b == '1) return want_rem ? '0 : a;
         if (want_rem) return $signed(a) % $signed(b);
         return $signed(a) / $signed(b);
      endfunction

      function logic [63:0] sx32(logic [63:0] v);
         return {{32{v[31]}}, v[31:0]};
      endfunction

      function void note_instruction(logic [31:0] ins);
         logic [6:0]   op;
         logic [4:0]   rd;
         logic [2:0]   f3;
         logic [6:0]   f7;
         logic [5:0]   f6, shamt;
         logic [63:0]  a, b, immi, imms, immb, immj, immu, val, npc, e;
         logic [127:0] prod;
         bit           wr, st, taken, bad, cond;
         rsp_word_type w;
         op = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12]; f7 = ins[31:25];
         f6 = ins[31:26]; shamt = ins[25:20];
         a = regs[ins[19:15]]; b = regs[ins[24:20]];
         immi = {{52{ins[31]}}, ins[31:20]};
         imms = {{52{ins[31]}}, ins[31:25], ins[11:7]};
         immb = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
         immj = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
         immu = {{32{ins[31]}}, ins[31:12], 12'd0};
         val = '0; npc = pc + 64'd4; w = '0;
         wr = 0; st = 0; taken = 0; bad = 0; cond = 0;
         case (op)
            OP_REG: begin
               wr = 1;
               if (f7 == F7_BASE) begin
                  case (f3)
                     F3_ADD: val = a + b;
                     F3_SLL: val = a << b[5:0];
                     F3_SLT: val = {63'd0, $signed(a) < $signed(b)};
                     F3_XOR: val = a ^ b;
                     F3_SR:  val = a >> b[5:0];
                     F3_OR:  val = a | b;
                     F3_AND: val = a & b;
                     default: bad = 1;
                  endcase
               end else if (f7 == F7_ALT && f3 == F3_ADD) val = a - b;
               else if (f7 == F7_ALT && f3 == F3_SR) val = $signed(a) >>> b[5:0];
               else if (f7 == F7_MD && f3 == F3_MUL) val = a * b;
               else if (f7 == F7_MD && f3 == F3_MULH) begin
                  prod = {{64{a[63]}}, a} * {{64{b[63]}}, b};
                  val = prod[127:64];
               end else if (f7 == F7_MD && f3 == F3_DIV) val = sdiv(a, b, 0);
               else if (f7 == F7_MD && f3 == F3_REM) val = sdiv(a, b, 1);
               else bad = 1;
            end
            OP_REGW: begin
               wr = 1;
               if (f7 == F7_BASE && f3 == F3_ADD) val = sx32(a + b);
               else if (f7 == F7_ALT && f3 == F3_ADD) val = sx32(a - b);
               else if (f7 == F7_MD && f3 == F3_MUL) val = sx32(a * b);
               else if (f7 == F7_MD && f3 == F3_DIV) val = sx32(sdiv(sx32(a), sx32(b), 0));
               else if (f7 == F7_MD && f3 == F3_REM) val = sx32(sdiv(sx32(a), sx32(b), 1));
               else bad = 1;
            end
            OP_LOAD: begin
               wr = 1;
               e = mem[12'((a + immi) >> 2)];
               case (f3)
                  F3_B: val = {{56{e[7]}}, e[7:0]};
                  F3_H: val = {{48{e[15]}}, e[15:0]};
                  F3_W: val = sx32(e);
                  F3_D: val = e;
                  default: bad = 1;
               endcase
            end
            OP_IMM: begin
               wr = 1;
               case (f3)
                  F3_ADD: val = a + immi;
                  F3_SLL: if (f6 == '0) val = a << shamt; else bad = 1;
                  F3_SLT: val = {63'd0, $signed(a) < $signed(immi)};
                  F3_XOR: val = a ^ immi;
                  F3_SR: begin
                     if (f6 == '0) val = a >> shamt;
                     else if (f6 == F6_SRA) val = $signed(a) >>> shamt;
                     else bad = 1;
                  end
                  F3_OR:  val = a | immi;
                  F3_AND: val = a & immi;
                  default: bad = 1;
               endcase
            end
            OP_IMMW: begin
               wr = 1;
               if (f3 == F3_ADD) val = sx32(a + immi); else bad = 1;
            end
            OP_STORE: begin
               if (f3 <= F3_D) begin
                  st = 1;
                  w.store_address = a + imms;
                  case (f3)
                     F3_B: w.store_value = {56'd0, b[7:0]};
                     F3_H: w.store_value = {48'd0, b[15:0]};
                     F3_W: w.store_value = {32'd0, b[31:0]};
                     default: w.store_value = b;
                  endcase
                  mem[12'(w.store_address >> 2)] = w.store_value;
               end else bad = 1;
            end
            OP_BRANCH: begin
               case (f3)
                  F3_BEQ: cond = (a == b);
                  F3_BNE: cond = (a != b);
                  F3_BLT: cond = $signed(a) < $signed(b);
                  F3_BGE: cond = !($signed(a) < $signed(b));
                  default: bad = 1;
               endcase
               if (cond) begin
                  taken = 1;
                  npc = pc + immb;
               end
            end
            OP_JAL: begin
               wr = 1; val = pc + 64'd4; taken = 1; npc = pc + immj;
            end
            OP_JALR: begin
               if (f3 == F3_ADD) begin
                  wr = 1; val = pc + 64'd4; taken = 1;
                  npc = (a + immi) & ~64'd1;
               end else bad = 1;
            end
            OP_LUI:    begin wr = 1; val = immu; end
            OP_AUIPC:  begin wr = 1; val = pc + immu; end
            OP_SYSTEM: if (!(f3 == '0 && f7 == '0)) bad = 1;
            default:   bad = 1;
         endcase
         if (bad) begin
            wr = 0; st = 0; taken = 0; npc = pc + 64'd4; val = '0;
         end
         if (rd == '0) wr = 0;
         if (wr) regs[rd] = val;
         pc = npc;
         w.next_pc = npc;
         w.reg_written = wr;
         w.dest_index = wr ? rd : '0;
         w.dest_value = wr ? val : '0;
         w.store_done = st;
         if (!st) begin
            w.store_address = '0;
            w.store_value = '0;
         end
         w.branch_taken = taken;
         w.illegal = bad;
         expected_words.push_back(w);
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type exp_w;
         if (expected_words.size() == 0) begin
            $error("result word with no instruction outstanding");
            errors++;
            return;
         end
         exp_w = expected_words.pop_front();
         if (got.next_pc !== exp_w.next_pc) begin
            $error("next_pc: expected %h, got %h", exp_w.next_pc, got.next_pc); errors++;
         end
         if (got.reg_written !== exp_w.reg_written) begin
            $error("reg_written: expected %0d, got %0d", exp_w.reg_written, got.reg_written);
            errors++;
         end
         if (got.dest_index !== exp_w.dest_index) begin
            $error("dest_index: expected %0d, got %0d", exp_w.dest_index, got.dest_index);
            errors++;
         end
         if (got.dest_value !== exp_w.dest_value) begin
            $error("dest_value: expected %h, got %h", exp_w.dest_value, got.dest_value);
            errors++;
         end
         if (got.store_done !== exp_w.store_done) begin
            $error("store_done: expected %0d, got %0d", exp_w.store_done, got.store_done);
            errors++;
         end
         if (got.store_address !== exp_w.store_address) begin
            $error("store_address: expected %h, got %h", exp_w.store_address,
                   got.store_address);
            errors++;
         end
         if (got.store_value !== exp_w.store_value) begin
            $error("store_value: expected %h, got %h", exp_w.store_value, got.store_value);
            errors++;
         end
         if (got.branch_taken !== exp_w.branch_taken) begin
            $error("branch_taken: expected %0d, got %0d", exp_w.branch_taken,
                   got.branch_taken);
            errors++;
         end
         if (got.illegal !== exp_w.illegal) begin
            $error("illegal: expected %0d, got %0d", exp_w.illegal, got.illegal); errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic        csr_index;
   logic [31:0] csr_data;
   int          idle_pct;
   int          stall_pct;
   bit          hold_req;
   rv64_scoreboard sb = new();

   rv64_req_if req ();
   rv64_rsp_if rsp ();

   rv64im_instruction_execute i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Overall time limit.
   initial begin
      #40_000_000;
      $display("Verification failed");
      $finish;
   end

   // Result receiver: random stalls, plus one long hold-off on request.
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 0;
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) sb.check_word(rsp.word);
   end

   // Instruction builders.
   function logic [31:0] r_ins(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                               logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
      return {f7, rs2, rs1, f3, rd, op};
   endfunction

   function logic [31:0] i_ins(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                               logic [4:0] rd, logic [6:0] op);
      return {imm, rs1, f3, rd, op};
   endfunction

   function logic [31:0] s_ins(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                               logic [2:0] f3);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
   endfunction

   function logic [31:0] b_ins(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                               logic [2:0] f3);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
   endfunction

   function logic [31:0] j_ins(logic [20:0] imm, logic [4:0] rd);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
   endfunction

   // Random instruction, mostly well formed, with some raw noise.
   function logic [31:0] random_instruction();
      logic [4:0]  rd, rs1, rs2;
      logic [11:0] imm;
      logic [2:0]  f3;
      int          pick;
      rd = 5'($urandom); rs1 = 5'($urandom); rs2 = 5'($urandom);
      imm = 12'($urandom); f3 = 3'($urandom);
      pick = $urandom_range(99);
      if (pick < 14) begin
         case ($urandom_range(7))
            0: return r_ins(F7_BASE, rs2, rs1, F3_ADD, rd, OP_REG);
            1: return r_ins(F7_ALT, rs2, rs1, F3_ADD, rd, OP_REG);
            2: return r_ins(F7_ALT, rs2, rs1, F3_SR, rd, OP_REG);
            default: return r_ins(F7_BASE, rs2, rs1, f3, rd, OP_REG);
         endcase
      end else if (pick < 20) begin
         case ($urandom_range(3))
            0: return r_ins(F7_MD, rs2, rs1, F3_MUL, rd, OP_REG);
            1: return r_ins(F7_MD, rs2, rs1, F3_MULH, rd, OP_REG);
            2: return r_ins(F7_MD, rs2, rs1, F3_DIV, rd, OP_REG);
            default: return r_ins(F7_MD, rs2, rs1, F3_REM, rd, OP_REG);
         endcase
      end else if (pick < 25) begin
         case ($urandom_range(4))
            0: return r_ins(F7_BASE, rs2, rs1, F3_ADD, rd, OP_REGW);
            1: return r_ins(F7_ALT, rs2, rs1, F3_ADD, rd, OP_REGW);
            2: return r_ins(F7_MD, rs2, rs1, F3_MUL, rd, OP_REGW);
            3: return r_ins(F7_MD, rs2, rs1, F3_DIV, rd, OP_REGW);
            default: return r_ins(F7_MD, rs2, rs1, F3_REM, rd, OP_REGW);
         endcase
      end else if (pick < 45) begin
         if (f3 == F3_SLL || f3 == F3_SR)
            imm[11:6] = ($urandom_range(9) == 0) ? 6'($urandom) :
                        (f3 == F3_SR && $urandom_range(1)) ? F6_SRA : 6'd0;
         return i_ins(imm, rs1, f3, rd, OP_IMM);
      end else if (pick < 49) return i_ins(imm, rs1, F3_ADD, rd, OP_IMMW);
      else if (pick < 57) return i_ins(imm, rs1, 3'($urandom_range(3)), rd, OP_LOAD);
      else if (pick < 66) return s_ins(imm, rs2, rs1, 3'($urandom_range(3)));
      else if (pick < 74) return b_ins(13'($urandom), rs2, rs1, f3);
      else if (pick < 77) return j_ins(21'($urandom), rd);
      else if (pick < 80) return i_ins(imm, rs1, F3_ADD, rd, OP_JALR);
      else if (pick < 87) return {20'($urandom), rd, OP_LUI};
      else if (pick < 91) return {20'($urandom), rd, OP_AUIPC};
      else if (pick < 93) return {25'd0, OP_SYSTEM};
      return $urandom;
   endfunction

   // Offer one instruction word and wait until it is taken.
   task automatic send_instruction(logic [31:0] ins);
      if ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req.valid <= 1'b1;
      req.instruction <= ins;
      do @(posedge clock); while (!req.ready);
      sb.note_instruction(ins);
   endtask

   // Wait for every outstanding result, then let the block settle.
   task automatic drain();
      req.valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the task then waits with the write enable low.
   task automatic write_csr(logic idx, logic [31:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.write_csr(idx, data);
      @(posedge clock);
   endtask

   // Directed corner cases: overflow, division by zero, x0, every class but OP_IMMW.
   task automatic run_directed();
      logic [31:0] seq [$];
      seq = '{
         {20'h80000, 5'd5, OP_LUI},
         i_ins(12'd32, 5'd5, F3_SLL, 5'd5, OP_IMM),
         i_ins(12'hfff, 5'd0, F3_ADD, 5'd6, OP_IMM),
         {20'h80000, 5'd9, OP_LUI},
         r_ins(F7_MD, 5'd6, 5'd5, F3_DIV, 5'd7, OP_REG),
         r_ins(F7_MD, 5'd6, 5'd5, F3_REM, 5'd8, OP_REG),
         r_ins(F7_MD, 5'd6, 5'd9, F3_DIV, 5'd10, OP_REGW),
         r_ins(F7_MD, 5'd6, 5'd9, F3_REM, 5'd10, OP_REGW),
         r_ins(F7_MD, 5'd0, 5'd5, F3_DIV, 5'd11, OP_REG),
         r_ins(F7_MD, 5'd0, 5'd5, F3_REM, 5'd12, OP_REG),
         r_ins(F7_MD, 5'd6, 5'd5, F3_MULH, 5'd13, OP_REG),
         r_ins(F7_MD, 5'd5, 5'd5, F3_MUL, 5'd14, OP_REG),
         i_ins(12'h43f, 5'd5, F3_SR, 5'd15, OP_IMM),
         i_ins(12'h7ff, 5'd6, F3_SLT, 5'd16, OP_IMM),
         r_ins(F7_BASE, 5'd6, 5'd6, F3_ADD, 5'd0, OP_REG),
         s_ins(12'h7f8, 5'd6, 5'd5, F3_D),
         i_ins(12'h7f8, 5'd5, F3_B, 5'd17, OP_LOAD),
         i_ins(12'h7f8, 5'd5, F3_H, 5'd18, OP_LOAD),
         i_ins(12'h7f8, 5'd5, F3_W, 5'd19, OP_LOAD),
         b_ins(13'h1ffc, 5'd6, 5'd5, F3_BLT),
         b_ins(13'h0ffe, 5'd6, 5'd5, F3_BGE),
         j_ins(21'h0ffffe, 5'd1),
         i_ins(12'h801, 5'd6, F3_ADD, 5'd1, OP_JALR),
         {20'hfffff, 5'd20, OP_AUIPC},
         {25'd0, OP_SYSTEM},
         r_ins(F7_BASE, 5'd6, 5'd5, F3_SLTU, 5'd21, OP_REG)
      };
      foreach (seq[i]) send_instruction(seq[i]);
   endtask

   // Main sequence: configure, run each idle and stall phase, then report.
   initial begin
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.instruction <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_START;
      csr_data <= '0;
      idle_pct = 0;
      stall_pct = 0;
      hold_req = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct = 0; stall_pct = 0;
               write_csr(CSR_START, 32'd0);
               write_csr(CSR_STACK, 32'd0);
            end
            1: begin
               idle_pct = 81; stall_pct = 0;
               write_csr(CSR_START, 32'hffff_fffc);
               write_csr(CSR_STACK, 32'hffff_ffff);
            end
            2: begin
               idle_pct = 0; stall_pct = 81;
               write_csr(CSR_START, $urandom);
               write_csr(CSR_STACK, $urandom);
            end
            default: begin
               idle_pct = 27; stall_pct = 27;
               write_csr(CSR_START, $urandom);
               write_csr(CSR_STACK, $urandom);
            end
         endcase
         if (phase == 0) begin
            hold_req = 1;
            run_directed();
         end
         repeat (RND_PER_PHASE) send_instruction(random_instruction());
         drain();
      end
      if (sb.errors == 0 && sb.expected_words.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
